>>> sv/octree_morton_key_unit_assert.svh
// ----------------------------------------------------------------------------
// Octree Morton key unit assertion macros
// Concurrent check wrappers clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef OCTREE_MORTON_KEY_UNIT_ASSERT_SVH
`define OCTREE_MORTON_KEY_UNIT_ASSERT_SVH

// Same-cycle implication.
`define OMK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OMK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/omk_pkg.sv
// ----------------------------------------------------------------------------
// omk_pkg
// Shared widths, codes, types and the key level function.
// ----------------------------------------------------------------------------
package omk_pkg;

  localparam int KEY_W     = 64;
  localparam int COORD_W   = 21;
  localparam int LEVEL_W   = 5;
  localparam int OP_W      = 2;
  localparam int ERR_W     = 2;
  localparam int OCT_W     = 3;
  // deepest level accepted by encode
  localparam int MAX_LEVEL = 21;
  // octants that fit below the sentinel in a key
  localparam int KEY_OCTS  = (KEY_W - 1) / OCT_W;

  localparam logic [OP_W-1:0] OP_ENCODE  = 2'd0;
  localparam logic [OP_W-1:0] OP_DECODE  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPARE = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_LEVEL = 2'd1;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;

  typedef struct packed {
    logic is_ancestor;
    logic is_descendant;
    logic is_equal;
  } cmp_flags_t;

  // Level = ceil(p/3) for top set bit p; 0 for keys 0 and 1.
  // Level i is reached when any bit at or above 3*i-2 is set.
  function automatic logic [LEVEL_W-1:0] key_level(input logic [KEY_W-1:0] k);
    logic [LEVEL_W-1:0] lvl;
    lvl = '0;
    for (int i = 1; i <= KEY_OCTS; i++) begin
      if (|(k >> (OCT_W * i - 2))) begin
        lvl = LEVEL_W'(i);
      end
    end
    return lvl;
  endfunction

endpackage

>>> sv/omk_encode.sv
// ----------------------------------------------------------------------------
// omk_encode
// Range checks and bit interleave of x/y/z into a sentinel key.
// ----------------------------------------------------------------------------
module omk_encode
  import omk_pkg::*;
(
  input  logic [LEVEL_W-1:0] level_in,
  input  logic [COORD_W-1:0] coord_x,
  input  logic [COORD_W-1:0] coord_y,
  input  logic [COORD_W-1:0] coord_z,
  output logic [KEY_W-1:0]   key,
  output logic [ERR_W-1:0]   err
);

  logic [KEY_W-1:0] ilv;
  logic [6:0]       sent_pos;

  always_comb begin
    ilv = '0;
    for (int i = 0; i < COORD_W; i++) begin
      ilv[OCT_W*i]     = coord_x[i];
      ilv[OCT_W*i + 1] = coord_y[i];
      ilv[OCT_W*i + 2] = coord_z[i];
    end
  end

  assign sent_pos = 7'({2'b00, level_in} * 7'd3);

  always_comb begin
    key = '0;
    err = ERR_NONE;
    if (level_in > LEVEL_W'(MAX_LEVEL)) begin
      err = ERR_LEVEL;
    end else if ((|(coord_x >> level_in)) || (|(coord_y >> level_in)) ||
                 (|(coord_z >> level_in))) begin
      err = ERR_RANGE;
    end else begin
      key = ilv | (KEY_W'(1) << sent_pos[5:0]);
    end
  end

endmodule

>>> sv/omk_decode.sv
// ----------------------------------------------------------------------------
// omk_decode
// De-interleave of the low octants of a key, gated by its level.
// ----------------------------------------------------------------------------
module omk_decode
  import omk_pkg::*;
(
  input  logic [KEY_W-1:0]   key,
  input  logic [LEVEL_W-1:0] level,
  output logic [COORD_W-1:0] x,
  output logic [COORD_W-1:0] y,
  output logic [COORD_W-1:0] z
);

  always_comb begin
    x = '0;
    y = '0;
    z = '0;
    for (int i = 0; i < COORD_W; i++) begin
      if (LEVEL_W'(i) < level) begin
        x[i] = key[OCT_W*i];
        y[i] = key[OCT_W*i + 1];
        z[i] = key[OCT_W*i + 2];
      end
    end
  end

endmodule

>>> sv/omk_compare.sv
// ----------------------------------------------------------------------------
// omk_compare
// Strict ancestry in both directions and equality of two keys.
// ----------------------------------------------------------------------------
module omk_compare
  import omk_pkg::*;
(
  input  logic [KEY_W-1:0]   key_a,
  input  logic [KEY_W-1:0]   key_b,
  input  logic [LEVEL_W-1:0] level_a,
  input  logic [LEVEL_W-1:0] level_b,
  output cmp_flags_t         flags
);

  // anc is a strict ancestor of dsc: shallower and equal to dsc's prefix
  function automatic logic anc_of(input logic [KEY_W-1:0]   anc,
                                  input logic [KEY_W-1:0]   dsc,
                                  input logic [LEVEL_W-1:0] la,
                                  input logic [LEVEL_W-1:0] ld);
    logic [LEVEL_W-1:0] diff;
    logic [6:0]         sh;
    diff = ld - la;
    sh   = 7'({2'b00, diff} * 7'd3);
    if (la >= ld || sh[6]) begin
      return 1'b0;
    end
    return anc == (dsc >> sh[5:0]);
  endfunction

  always_comb begin
    flags.is_ancestor   = anc_of(key_a, key_b, level_a, level_b);
    flags.is_descendant = anc_of(key_b, key_a, level_b, level_a);
    flags.is_equal      = (key_a == key_b);
  end

endmodule

>>> sv/octree_morton_key_unit.sv
// ----------------------------------------------------------------------------
// octree_morton_key_unit
// Octree key encode, decode and ancestry compare; one item per cycle unless out_ready stalls.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries an opcode plus the operands for
//   encode (level, x/y/z), decode (key A) or compare (key A vs key B).
//   Result channel (out_valid/out_ready) returns exactly one result per input
//   transfer, in order. Fields that the opcode does not produce read 0;
//   opcode 3 yields an all-zero result.
//   Path: an accepted item is held in the input register, then moves to the
//   result register, where out_valid rises and the result can transfer.
//   Throughput: one transfer per cycle, sustained, because both register
//   stages advance together whenever the result slot is free or being
//   drained.
//   The whole operation (interleave, leading-one level detect, shift-compare)
//   is combinational between the two registers.
//   Reset (rst_n low, synchronous) empties both stages; no result is pending.
//   Receiver stall: the result holds in the output register; an empty input
//   stage still takes one more item, then in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
module octree_morton_key_unit
  import omk_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic [LEVEL_W-1:0] in_level_in,
  input  logic [COORD_W-1:0] in_coord_x,
  input  logic [COORD_W-1:0] in_coord_y,
  input  logic [COORD_W-1:0] in_coord_z,
  input  logic [KEY_W-1:0]   in_key_a,
  input  logic [KEY_W-1:0]   in_key_b,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KEY_W-1:0]   out_key_out,
  output logic [LEVEL_W-1:0] out_level_out,
  output logic [COORD_W-1:0] out_x_out,
  output logic [COORD_W-1:0] out_y_out,
  output logic [COORD_W-1:0] out_z_out,
  output logic [ERR_W-1:0]   out_error_code,
  output logic               out_is_ancestor,
  output logic               out_is_descendant,
  output logic               out_is_equal
);

  // --- stage control -------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic adv;    // result register can load this cycle
  logic in_xfer;

  // --- input register ------------------------------------------------------
  logic [OP_W-1:0]    op_r;
  logic [LEVEL_W-1:0] lvl_r;
  logic [COORD_W-1:0] cx_r, cy_r, cz_r;
  logic [KEY_W-1:0]   ka_r, kb_r;

  // --- datapath ------------------------------------------------------------
  logic [LEVEL_W-1:0] level_a, level_b;
  logic [KEY_W-1:0]   enc_key;
  logic [ERR_W-1:0]   enc_err;
  logic [COORD_W-1:0] dec_x, dec_y, dec_z;
  cmp_flags_t         cmp_flags;

  // --- result register -----------------------------------------------------
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [LEVEL_W-1:0] lvl_out_r, lvl_out_nxt;
  logic [COORD_W-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [ERR_W-1:0]   err_r, err_nxt;
  cmp_flags_t         flags_r, flags_nxt;

  // The result slot frees when empty or drained; input stage then shifts.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || adv;
  assign in_xfer  = in_valid && in_ready;

  assign s1_valid_nxt  = in_xfer ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= in_opcode;
      lvl_r <= in_level_in;
      cx_r  <= in_coord_x;
      cy_r  <= in_coord_y;
      cz_r  <= in_coord_z;
      ka_r  <= in_key_a;
      kb_r  <= in_key_b;
    end
  end

  // Leading-one level detect, shared by decode and compare.
  assign level_a = key_level(ka_r);
  assign level_b = key_level(kb_r);

  omk_encode u_encode (
    .level_in (lvl_r),
    .coord_x  (cx_r),
    .coord_y  (cy_r),
    .coord_z  (cz_r),
    .key      (enc_key),
    .err      (enc_err)
  );

  omk_decode u_decode (
    .key   (ka_r),
    .level (level_a),
    .x     (dec_x),
    .y     (dec_y),
    .z     (dec_z)
  );

  omk_compare u_compare (
    .key_a   (ka_r),
    .key_b   (kb_r),
    .level_a (level_a),
    .level_b (level_b),
    .flags   (cmp_flags)
  );

  // Opcode select: unused fields stay zero.
  always_comb begin
    key_nxt     = '0;
    lvl_out_nxt = '0;
    x_nxt       = '0;
    y_nxt       = '0;
    z_nxt       = '0;
    err_nxt     = ERR_NONE;
    flags_nxt   = '0;
    unique case (op_r)
      OP_ENCODE: begin
        key_nxt = enc_key;
        err_nxt = enc_err;
      end
      OP_DECODE: begin
        lvl_out_nxt = level_a;
        x_nxt       = dec_x;
        y_nxt       = dec_y;
        z_nxt       = dec_z;
      end
      OP_COMPARE: begin
        lvl_out_nxt = level_a;
        flags_nxt   = cmp_flags;
      end
      default: begin
        key_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      key_r     <= key_nxt;
      lvl_out_r <= lvl_out_nxt;
      x_r       <= x_nxt;
      y_r       <= y_nxt;
      z_r       <= z_nxt;
      err_r     <= err_nxt;
      flags_r   <= flags_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_key_out       = key_r;
  assign out_level_out     = lvl_out_r;
  assign out_x_out         = x_r;
  assign out_y_out         = y_r;
  assign out_z_out         = z_r;
  assign out_error_code    = err_r;
  assign out_is_ancestor   = flags_r.is_ancestor;
  assign out_is_descendant = flags_r.is_descendant;
  assign out_is_equal      = flags_r.is_equal;

  // --- checks --------------------------------------------------------------
`include "octree_morton_key_unit_assert.svh"

  `OMK_ASSERT_NOW(a_flags_exclusive, out_valid_r, $onehot0(flags_r), "compare flags overlap")
  `OMK_ASSERT_NOW(a_err_key, out_valid_r && (err_r != ERR_NONE), key_r == '0, "key on error")
  `OMK_ASSERT_NEXT(a_in_lands, in_xfer, s1_valid_r, "accepted item not held in input stage")
  `OMK_ASSERT_NEXT(a_stage_moves, s1_valid_r && !out_valid_r, out_valid_r, "stage stuck")

endmodule
